// ===== rtl/oled_display_command_and_ram_port_unit_macros.svh =====
// Assertion macros shared by the command and RAM port checker.
`ifndef OLED_DISPLAY_COMMAND_AND_RAM_PORT_UNIT_MACROS_SVH
`define OLED_DISPLAY_COMMAND_AND_RAM_PORT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define ODCRP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define ODCRP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/odcrp_pkg.sv =====
// Package with types, opcodes and sizes of the OLED command and RAM port.
package odcrp_pkg;

   // RAM geometry
   localparam int RAM_ROWS   = 80;
   localparam int ROW_STRIDE = 64;
   localparam int RAM_DEPTH  = RAM_ROWS * ROW_STRIDE;
   localparam int RAM_AW     = $clog2(RAM_DEPTH);
   localparam logic [7:0] RAM_ROWS_W = 8'(RAM_ROWS);

   // Register reset values
   localparam logic [5:0] COL_END_RST  = 6'h3F;
   localparam logic [6:0] ROW_END_RST  = 7'h4F;
   localparam logic [6:0] CONTRAST_RST = 7'h40;

   // Opcodes with an effect or a long parameter list
   localparam logic [7:0] OP_SET_COLUMN = 8'h15;
   localparam logic [7:0] OP_SET_ROW    = 8'h75;
   localparam logic [7:0] OP_CONTRAST   = 8'h81;
   localparam logic [7:0] OP_REMAP      = 8'hA0;
   localparam logic [7:0] OP_LEN4       = 8'h26;
   localparam logic [7:0] OP_LEN6       = 8'h24;
   localparam logic [7:0] OP_LEN7       = 8'h25;
   localparam logic [7:0] OP_LEN9       = 8'hB8;

   // Bus access kinds
   typedef enum logic [1:0] {
      CMD_BYTE  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_ABORT = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [5:0] column_now;
      logic [6:0] row_now;
      logic [6:0] contrast_level;
      logic [6:0] remap_bits;
      logic       command_done;
      logic       bad_opcode;
      logic       out_of_range;
   } rsp_type;

   // Total command length in bytes for an opcode; zero for an unknown opcode
   function automatic logic [3:0] opcode_length(input logic [7:0] op);
      logic [3:0] len;
      case (op)
         8'h2E, 8'h2F, 8'h84, 8'h85, 8'h86,
         8'hA4, 8'hA5, 8'hA6, 8'hA7,
         8'hAE, 8'hAF, 8'hE3:                  len = 4'd1;
         8'h23, OP_CONTRAST, OP_REMAP, 8'hA1, 8'hA2, 8'hA8,
         8'hAD, 8'hB0, 8'hB1, 8'hB2, 8'hB3, 8'hB4,
         8'hBC, 8'hBE, 8'hBF:                  len = 4'd2;
         OP_SET_COLUMN, OP_SET_ROW:            len = 4'd3;
         OP_LEN4:                              len = 4'd4;
         OP_LEN6:                              len = 4'd6;
         OP_LEN7:                              len = 4'd7;
         OP_LEN9:                              len = 4'd9;
         default:                              len = 4'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/oled_display_command_and_ram_port_unit.sv =====
// Command decoder, address counters and display RAM port of the OLED controller.
// A result is registered and shown in the cycle after its request is accepted.
// Throughput: one request per cycle while no result is stalled; the display RAM
// takes at most one access per request on its single port, read data registered.
// Reset (synchronous, active high) restores the window, address, contrast and
// remap registers and drops any pending command; display RAM contents are kept.
module oled_display_command_and_ram_port_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  odcrp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output odcrp_pkg::rsp_type rsp_data
);
   import odcrp_pkg::*;

   // Architectural state
   logic [5:0] col_start_ff, col_start_in;
   logic [5:0] col_end_ff,   col_end_in;
   logic [6:0] row_start_ff, row_start_in;
   logic [6:0] row_end_ff,   row_end_in;
   logic [5:0] col_ff,       col_in;
   logic [6:0] row_ff,       row_in;
   logic [6:0] remap_ff,     remap_in;
   logic [6:0] contrast_ff,  contrast_in;
   logic [3:0] pos_ff,       pos_in;
   logic [3:0] exp_ff,       exp_in;
   logic [7:0] pend_ff [0:2];
   logic [7:0] pend_in [0:2];

   // Result stage
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   logic       rd_sel_ff;

   // Display RAM
   logic [7:0] display_ram_ff [0:RAM_DEPTH-1];
   logic [7:0] ram_q_ff;
   logic [RAM_AW-1:0] ram_addr;
   logic       ram_we;
   logic       ram_re;

   logic       accept;
   logic       row_in_ram;
   logic       done;
   logic       bad;
   logic       oor;
   logic [3:0] len;
   logic [3:0] pos_inc;

   // Address stepping for both axes
   logic [6:0] col_inc;
   logic       col_wrap;
   logic [5:0] col_step;
   logic [7:0] row_inc;
   logic       row_wrap;
   logic [6:0] row_step;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = rsp_valid_ff & rsp_stall;

   assign col_inc  = {1'b0, col_ff} + 7'd1;
   assign col_wrap = col_inc > {1'b0, col_end_ff};
   assign col_step = col_wrap ? col_start_ff : col_inc[5:0];
   assign row_inc  = {1'b0, row_ff} + 8'd1;
   assign row_wrap = row_inc > {1'b0, row_end_ff};
   assign row_step = row_wrap ? row_start_ff : row_inc[6:0];

   assign row_in_ram = {1'b0, row_ff} < RAM_ROWS_W;
   assign ram_addr   = RAM_AW'({row_ff, col_ff});
   assign len        = opcode_length(req_data.byte_value);
   assign pos_inc    = pos_ff + 4'd1;

   // Decode the request and work out the next state
   always_comb begin
      col_start_in = col_start_ff;
      col_end_in   = col_end_ff;
      row_start_in = row_start_ff;
      row_end_in   = row_end_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      remap_in     = remap_ff;
      contrast_in  = contrast_ff;
      pos_in       = pos_ff;
      exp_in       = exp_ff;
      pend_in      = pend_ff;
      done         = 1'b0;
      bad          = 1'b0;
      oor          = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      case (req_data.command)
         CMD_BYTE: begin
            if (pos_ff == 4'd0) begin
               // opcode byte
               if (len == 4'd0) begin
                  bad = 1'b1;
               end else begin
                  pend_in[0] = req_data.byte_value;
                  if (len == 4'd1) begin
                     done   = 1'b1;
                     exp_in = 4'd0;
                  end else begin
                     exp_in = len;
                     pos_in = 4'd1;
                  end
               end
            end else begin
               // parameter byte: keep the first two, count the rest
               if (pos_ff < 4'd3) begin
                  pend_in[pos_ff[1:0]] = req_data.byte_value;
               end
               pos_in = pos_inc;
               if (pos_inc >= exp_ff) begin
                  done   = 1'b1;
                  pos_in = 4'd0;
                  exp_in = 4'd0;
                  case (pend_in[0])
                     OP_CONTRAST: contrast_in = pend_in[1][6:0];
                     OP_REMAP:    remap_in    = pend_in[1][6:0];
                     OP_SET_COLUMN: begin
                        col_start_in = pend_in[1][5:0];
                        col_end_in   = pend_in[2][5:0];
                        col_in       = pend_in[1][5:0];
                     end
                     OP_SET_ROW: begin
                        row_start_in = pend_in[1][6:0];
                        row_end_in   = pend_in[2][6:0];
                        row_in       = pend_in[1][6:0];
                     end
                     default: ;
                  endcase
               end
            end
         end
         CMD_WRITE: begin
            ram_we = row_in_ram;
            oor    = ~row_in_ram;
            if (remap_ff[2]) begin
               // vertical increment, carry once into the column
               row_in = row_step;
               if (row_wrap && (col_start_ff != col_end_ff)) begin
                  col_in = col_step;
               end
            end else begin
               col_in = col_step;
               if (col_wrap && (row_start_ff != row_end_ff)) begin
                  row_in = row_step;
               end
            end
         end
         CMD_READ: begin
            ram_re = row_in_ram;
            oor    = ~row_in_ram;
            col_in = col_step;
            if (col_wrap && (row_start_ff != row_end_ff)) begin
               row_in = row_step;
            end
         end
         CMD_ABORT: begin
            pos_in = 4'd0;
            exp_in = 4'd0;
         end
         default: ;
      endcase
   end

   // Hold state; advance on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         col_start_ff <= '0;
         col_end_ff   <= COL_END_RST;
         row_start_ff <= '0;
         row_end_ff   <= ROW_END_RST;
         col_ff       <= '0;
         row_ff       <= '0;
         remap_ff     <= '0;
         contrast_ff  <= CONTRAST_RST;
         pos_ff       <= '0;
         exp_ff       <= '0;
         pend_ff      <= '{default: '0};
      end else if (accept) begin
         col_start_ff <= col_start_in;
         col_end_ff   <= col_end_in;
         row_start_ff <= row_start_in;
         row_end_ff   <= row_end_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         remap_ff     <= remap_in;
         contrast_ff  <= contrast_in;
         pos_ff       <= pos_in;
         exp_ff       <= exp_in;
         pend_ff      <= pend_in;
      end
   end

   // Display RAM: at most one write or one registered read per request
   always_ff @(posedge clock) begin
      if (accept && ram_we) begin
         display_ram_ff[ram_addr] <= req_data.byte_value;
      end
      if (accept && ram_re) begin
         ram_q_ff <= display_ram_ff[ram_addr];
      end
   end

   // Result valid: set on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff.read_data      <= '0;
         rsp_ff.column_now     <= col_in;
         rsp_ff.row_now        <= row_in;
         rsp_ff.contrast_level <= contrast_in;
         rsp_ff.remap_bits     <= remap_in;
         rsp_ff.command_done   <= done;
         rsp_ff.bad_opcode     <= bad;
         rsp_ff.out_of_range   <= oor;
         rd_sel_ff             <= ram_re;
      end
   end

   // Merge the RAM read data into the result
   always_comb begin
      rsp_data           = rsp_ff;
      rsp_data.read_data = rd_sel_ff ? ram_q_ff : 8'd0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/odcrp_checker.sv =====
// Port checker for the OLED command and RAM port, bound to the port unit.
`include "oled_display_command_and_ram_port_unit_macros.svh"

module odcrp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input odcrp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input odcrp_pkg::rsp_type rsp_data
);
   import odcrp_pkg::*;

   logic accept;

   assign accept = req_valid && !req_stall;

   // A stalled result stays put
   `ODCRP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

   // No new request while the result slot is full and stalled
   `ODCRP_ASSERT_IMPL(a_no_overrun, rsp_valid && rsp_stall, req_stall, "request taken over a stalled result")

   // An abort shows a result with no flags
   `ODCRP_ASSERT_NEXT(a_abort_quiet, accept && (req_data.command == CMD_ABORT), rsp_valid && !rsp_data.command_done && !rsp_data.bad_opcode && !rsp_data.out_of_range, "abort raised a flag")

   // A dropped opcode neither completes a command nor touches RAM
   `ODCRP_ASSERT_IMPL(a_bad_alone, rsp_valid && rsp_data.bad_opcode, !rsp_data.command_done && !rsp_data.out_of_range, "bad opcode with other flags")

endmodule

bind oled_display_command_and_ram_port_unit odcrp_checker u_odcrp_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the OLED command decoder and display RAM port.
`timescale 1ns / 1ps

module testbench;
   import odcrp_pkg::*;

   // Opcodes by command length; the effective ones come from the package
   localparam logic [7:0] ONE_BYTE_OPS [0:11] = '{8'h2E, 8'h2F, 8'h84, 8'h85, 8'h86, 8'hA4,
                                                  8'hA5, 8'hA6, 8'hA7, 8'hAE, 8'hAF, 8'hE3};
   localparam logic [7:0] TWO_BYTE_OPS [0:14] = '{8'h23, OP_CONTRAST, OP_REMAP, 8'hA1, 8'hA2,
                                                  8'hA8, 8'hAD, 8'hB0, 8'hB1, 8'hB2, 8'hB3,
                                                  8'hB4, 8'hBC, 8'hBE, 8'hBF};
   localparam logic [7:0] LONG_OPS [0:5] = '{OP_SET_COLUMN, OP_SET_ROW, OP_LEN4, OP_LEN6,
                                             OP_LEN7, OP_LEN9};
   localparam int IDLE_PERCENT = 21;
   localparam int DRAIN_CYCLES = 4;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Predicted port state
   logic [5:0] col_lo = '0, col_hi = COL_END_RST, col_ptr = '0;
   logic [6:0] row_lo = '0, row_hi = ROW_END_RST, row_ptr = '0;
   logic [6:0] remap_q = '0, contrast_q = CONTRAST_RST;
   logic [3:0] cmd_pos = '0, cmd_len = '0;
   logic [7:0] cmd_bytes [0:2] = '{8'h00, 8'h00, 8'h00};
   logic [7:0] ram_image [RAM_DEPTH];
   bit         ram_written [RAM_DEPTH];

   rsp_type port_status_q [$];
   bit      throttle = 1'b1;
   int      mismatches = 0;
   int      accepted_count = 0;
   int      n_reads = 0, n_writes = 0, n_done = 0, n_bad = 0, n_oor = 0;

   oled_display_command_and_ram_port_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", port_status_q.size());
      $display("status: fail");
      $finish;
   end

   // Total bytes of a command; zero marks an unknown opcode
   function automatic logic [3:0] length_of(input logic [7:0] op);
      foreach (ONE_BYTE_OPS[i]) if (ONE_BYTE_OPS[i] == op) return 4'd1;
      foreach (TWO_BYTE_OPS[i]) if (TWO_BYTE_OPS[i] == op) return 4'd2;
      case (op)
         OP_SET_COLUMN, OP_SET_ROW: return 4'd3;
         OP_LEN4: return 4'd4;
         OP_LEN6: return 4'd6;
         OP_LEN7: return 4'd7;
         OP_LEN9: return 4'd9;
         default: return 4'd0;
      endcase
   endfunction

   // Step one axis inside its window; report a wrap
   function automatic bit bump_column();
      if ({1'b0, col_ptr} + 7'd1 <= {1'b0, col_hi}) begin
         col_ptr = col_ptr + 6'd1;
         return 1'b0;
      end
      col_ptr = col_lo;
      return 1'b1;
   endfunction

   function automatic bit bump_row();
      if ({1'b0, row_ptr} + 8'd1 <= {1'b0, row_hi}) begin
         row_ptr = row_ptr + 7'd1;
         return 1'b0;
      end
      row_ptr = row_lo;
      return 1'b1;
   endfunction

   // Carry a wrap into the other axis once
   function automatic void move_across();
      if (bump_column() && row_lo != row_hi) void'(bump_row());
   endfunction

   function automatic void move_down();
      if (bump_row() && col_lo != col_hi) void'(bump_column());
   endfunction

   function automatic void apply_command();
      case (cmd_bytes[0])
         OP_CONTRAST: contrast_q = cmd_bytes[1][6:0];
         OP_REMAP:    remap_q = cmd_bytes[1][6:0];
         OP_SET_COLUMN: begin
            col_lo  = cmd_bytes[1][5:0];
            col_hi  = cmd_bytes[2][5:0];
            col_ptr = col_lo;
         end
         OP_SET_ROW: begin
            row_lo  = cmd_bytes[1][6:0];
            row_hi  = cmd_bytes[2][6:0];
            row_ptr = row_lo;
         end
         default: ;
      endcase
   endfunction

   // Advance the predicted state by one request and return its status
   function automatic rsp_type compute_port_response(input req_type rq);
      rsp_type    rs;
      logic [3:0] len;
      logic [12:0] addr;
      rs = '0;
      addr = {row_ptr[6:0], col_ptr};
      case (rq.command)
         CMD_BYTE: begin
            if (cmd_pos == 4'd0) begin
               len = length_of(rq.byte_value);
               if (len == 4'd0) begin
                  rs.bad_opcode = 1'b1;
               end else begin
                  cmd_bytes[0] = rq.byte_value;
                  if (len == 4'd1) begin
                     rs.command_done = 1'b1;
                     cmd_len = 4'd0;
                  end else begin
                     cmd_len = len;
                     cmd_pos = 4'd1;
                  end
               end
            end else begin
               if (cmd_pos < 4'd3) cmd_bytes[cmd_pos[1:0]] = rq.byte_value;
               cmd_pos = cmd_pos + 4'd1;
               if (cmd_pos >= cmd_len) begin
                  apply_command();
                  rs.command_done = 1'b1;
                  cmd_pos = 4'd0;
                  cmd_len = 4'd0;
               end
            end
         end
         CMD_WRITE: begin
            if (row_ptr < RAM_ROWS) begin
               ram_image[addr] = rq.byte_value;
               ram_written[addr] = 1'b1;
            end else begin
               rs.out_of_range = 1'b1;
            end
            if (remap_q[2]) move_down();
            else move_across();
         end
         CMD_READ: begin
            if (row_ptr < RAM_ROWS) rs.read_data = ram_image[addr];
            else rs.out_of_range = 1'b1;
            move_across();
         end
         CMD_ABORT: begin
            cmd_pos = 4'd0;
            cmd_len = 4'd0;
         end
         default: ;
      endcase
      rs.column_now     = col_ptr;
      rs.row_now        = row_ptr;
      rs.contrast_level = contrast_q;
      rs.remap_bits     = remap_q;
      return rs;
   endfunction

   // A read is legal only outside the RAM or on an entry already written
   function automatic bit read_defined();
      if (row_ptr >= RAM_ROWS) return 1'b1;
      return ram_written[{row_ptr, col_ptr}];
   endfunction

   // Present one request, hold it until accepted, then queue its status
   task automatic send_request(input cmd_type kind, input logic [7:0] value);
      req_type rq;
      rsp_type rs;
      if (kind == CMD_READ && !read_defined()) kind = CMD_WRITE;
      rq.command = kind;
      rq.byte_value = value;
      while (throttle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      rs = compute_port_response(rq);
      port_status_q.push_back(rs);
      accepted_count++;
      n_reads  += (kind == CMD_READ);
      n_writes += (kind == CMD_WRITE);
      n_done   += rs.command_done;
      n_bad    += rs.bad_opcode;
      n_oor    += rs.out_of_range;
   endtask

   // Drop valid and wait for every queued status
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (port_status_q.size() != 0);
   endtask

   // Send an opcode followed by random parameter bytes
   task automatic send_full_command(input logic [7:0] op);
      logic [3:0] len;
      len = length_of(op);
      send_request(CMD_BYTE, op);
      for (int i = 1; i < len; i++) send_request(CMD_BYTE, 8'($urandom));
   endtask

   task automatic send_column_window();
      int lo, hi;
      lo = $urandom_range(0, 63);
      hi = lo + $urandom_range(0, 3);
      if (hi > 63) hi = 63;
      if ($urandom_range(0, 99) < 10) hi = $urandom_range(0, 63);
      send_request(CMD_BYTE, OP_SET_COLUMN);
      send_request(CMD_BYTE, {2'($urandom), 6'(lo)});
      send_request(CMD_BYTE, {2'($urandom), 6'(hi)});
   endtask

   task automatic send_row_window();
      int lo, hi;
      lo = ($urandom_range(0, 99) < 85) ? $urandom_range(0, RAM_ROWS - 1)
                                         : $urandom_range(RAM_ROWS, 127);
      hi = lo + $urandom_range(0, 3);
      if (hi > 127) hi = 127;
      if ($urandom_range(0, 99) < 10) hi = $urandom_range(0, 127);
      send_request(CMD_BYTE, OP_SET_ROW);
      send_request(CMD_BYTE, {1'($urandom), 7'(lo)});
      send_request(CMD_BYTE, {1'($urandom), 7'(hi)});
   endtask

   // Mix well-formed command sequences and data bursts with some noise
   task automatic run_traffic(input int count);
      int         target, pick, n;
      logic [7:0] op, b;
      logic [3:0] len;
      target = accepted_count + count;
      while (accepted_count < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            send_column_window();
         end else if (pick < 28) begin
            send_row_window();
         end else if (pick < 34) begin
            send_request(CMD_BYTE, OP_REMAP);
            send_request(CMD_BYTE, 8'($urandom));
         end else if (pick < 38) begin
            send_request(CMD_BYTE, OP_CONTRAST);
            send_request(CMD_BYTE, 8'($urandom));
         end else if (pick < 46) begin
            case ($urandom_range(0, 2))
               0: op = ONE_BYTE_OPS[$urandom_range(0, 11)];
               1: op = TWO_BYTE_OPS[$urandom_range(0, 14)];
               default: op = LONG_OPS[$urandom_range(2, 5)];
            endcase
            send_full_command(op);
         end else if (pick < 66) begin
            n = $urandom_range(1, 8);
            repeat (n) send_request(CMD_WRITE, 8'($urandom));
         end else if (pick < 86) begin
            n = $urandom_range(1, 8);
            repeat (n) send_request(CMD_READ, 8'($urandom));
         end else begin
            case ($urandom_range(0, 4))
               0: begin
                  do b = 8'($urandom); while (length_of(b) != 4'd0);
                  send_request(CMD_BYTE, b);
               end
               1: send_request(CMD_ABORT, 8'($urandom));
               2: begin
                  // cut a command short
                  op = LONG_OPS[$urandom_range(0, 5)];
                  len = length_of(op);
                  send_request(CMD_BYTE, op);
                  repeat ($urandom_range(0, len - 2)) send_request(CMD_BYTE, 8'($urandom));
                  send_request(CMD_ABORT, 8'($urandom));
               end
               3: begin
                  // slip data accesses into a command being gathered
                  op = LONG_OPS[$urandom_range(2, 5)];
                  len = length_of(op);
                  send_request(CMD_BYTE, op);
                  send_request(CMD_BYTE, 8'($urandom));
                  repeat ($urandom_range(1, 2))
                     send_request(($urandom_range(0, 1) != 0) ? CMD_READ : CMD_WRITE,
                                  8'($urandom));
                  for (int i = 2; i < len; i++) send_request(CMD_BYTE, 8'($urandom));
               end
               default: send_request(cmd_type'($urandom_range(0, 3)), 8'($urandom));
            endcase
         end
      end
   endtask

   // Extremes, masking, flags, wraps and carries, out-of-range rows
   task automatic test_directed_cases();
      send_request(CMD_WRITE, 8'hFF);
      send_request(CMD_BYTE, ONE_BYTE_OPS[10]);
      send_request(CMD_BYTE, 8'h00);
      send_request(CMD_BYTE, 8'hFF);
      send_request(CMD_BYTE, OP_CONTRAST);
      send_request(CMD_ABORT, 8'hFF);
      send_request(CMD_BYTE, OP_CONTRAST);
      send_request(CMD_BYTE, 8'h80);
      send_request(CMD_BYTE, OP_REMAP);
      send_request(CMD_BYTE, 8'hFF);
      // two-by-two window in the last RAM rows, vertical increment
      send_request(CMD_BYTE, OP_SET_COLUMN);
      send_request(CMD_BYTE, 8'hFE);
      send_request(CMD_BYTE, 8'hFF);
      send_request(CMD_BYTE, OP_SET_ROW);
      send_request(CMD_BYTE, 8'hCE);
      send_request(CMD_BYTE, 8'h4F);
      send_request(CMD_WRITE, 8'h5A);
      send_request(CMD_WRITE, 8'hA5);
      send_request(CMD_WRITE, 8'hFF);
      send_request(CMD_WRITE, 8'h00);
      send_request(CMD_READ, 8'h00);
      send_request(CMD_READ, 8'hFF);
      // row past the RAM
      send_request(CMD_BYTE, OP_SET_ROW);
      send_request(CMD_BYTE, 8'h7F);
      send_request(CMD_BYTE, 8'hFF);
      send_request(CMD_WRITE, 8'h3C);
      send_request(CMD_READ, 8'h00);
   endtask

   task automatic test_mixed_traffic(input int count);
      throttle = 1'b1;
      run_traffic(count);
   endtask

   task automatic test_drain_pause();
      throttle = 1'b1;
      run_traffic(30);
      hold_until_drained();
   endtask

   task automatic test_full_rate(input int count);
      throttle = 1'b0;
      run_traffic(count);
      throttle = 1'b1;
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Compare each accepted status with the oldest prediction; randomize the stall
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (port_status_q.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected status %h", $time, rsp_data);
         end else begin
            want = port_status_q.pop_front();
            check_field("read_data", want.read_data, rsp_data.read_data);
            check_field("column_now", 8'(want.column_now), 8'(rsp_data.column_now));
            check_field("row_now", 8'(want.row_now), 8'(rsp_data.row_now));
            check_field("contrast_level", 8'(want.contrast_level), 8'(rsp_data.contrast_level));
            check_field("remap_bits", 8'(want.remap_bits), 8'(rsp_data.remap_bits));
            check_field("command_done", 8'(want.command_done), 8'(rsp_data.command_done));
            check_field("bad_opcode", 8'(want.bad_opcode), 8'(rsp_data.bad_opcode));
            check_field("out_of_range", 8'(want.out_of_range), 8'(rsp_data.out_of_range));
         end
      end
      rsp_stall <= throttle && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_mixed_traffic(200);
      test_drain_pause();
      test_full_rate(100);
      test_mixed_traffic(100);
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("requests %0d: %0d writes, %0d reads, %0d commands completed", accepted_count,
               n_writes, n_reads, n_done);
      $display("unknown opcodes %0d, out-of-range accesses %0d, mismatches %0d", n_bad, n_oor,
               mismatches);
      if (mismatches == 0 && port_status_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
